@@ sv/flas_pkg.sv @@
// ----------------------------------------------------------------------------
// flas_pkg
// Shared widths, register indexes, controller states, command bundle and
// saturation helper for the four-level adaptive slicer.
// ----------------------------------------------------------------------------
`default_nettype none

package flas_pkg;

   // Sample and state formats
   localparam int SAMPLE_BITS = 16;
   localparam int FRAC_EXTRA  = 8;
   localparam int STATE_BITS  = SAMPLE_BITS + FRAC_EXTRA;
   localparam int GAIN_BITS   = 16;

   // Gain step: (b - a) * g, rounded half up, then added to a
   localparam int DIFF_BITS = STATE_BITS + 1;
   localparam int PROD_BITS = DIFF_BITS + GAIN_BITS + 1;
   localparam int STEP_BITS = PROD_BITS - GAIN_BITS;
   localparam int SUM_BITS  = STEP_BITS + 1;

   // Divide by three: floor(m / 3) = (m * ceil(2^s / 3)) >> s for m < 2^(s-1)
   localparam int DIV_SHIFT     = STATE_BITS + 2;
   localparam int MAG_BITS      = STATE_BITS + 1;
   localparam int DIV_PROD_BITS = MAG_BITS + DIV_SHIFT;
   localparam logic [DIV_SHIFT-1:0] RECIP3 =
      DIV_SHIFT'(((64'd1 << DIV_SHIFT) + 64'd2) / 64'd3);

   // Register indexes
   localparam int CSR_IDX_BITS = 1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_AVG_GAIN   = 1'b0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_DECAY_GAIN = 1'b1;

   localparam logic [GAIN_BITS-1:0] AVG_GAIN_RESET   = 16'd655;
   localparam logic [GAIN_BITS-1:0] DECAY_GAIN_RESET = 16'd7;

   // Controller states, one per step of an item
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DC_MUL,
      ST_DC_UPD,
      ST_CENTER,
      ST_DECIDE,
      ST_LV_MUL,
      ST_LV_UPD,
      ST_TH_MUL,
      ST_TH_UPD,
      ST_DONE
   } state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic load_x;
      logic dc_mul;
      logic dc_upd;
      logic center;
      logic decide;
      logic lv_mul;
      logic lv_upd;
      logic th_mul;
      logic th_upd;
      logic load_rsp;
   } cmd_type;

   // Clamp a wide signed value to the signed state range
   function automatic logic signed [STATE_BITS-1:0] sat_state(
      input logic signed [SUM_BITS-1:0] v);
      logic [SUM_BITS-STATE_BITS:0] top;
      logic signed [STATE_BITS-1:0] r;
      top = v[SUM_BITS-1:STATE_BITS-1];
      if (top == '0 || top == '1) begin
         r = v[STATE_BITS-1:0];
      end else if (v[SUM_BITS-1]) begin
         r = {1'b1, {(STATE_BITS-1){1'b0}}};
      end else begin
         r = {1'b0, {(STATE_BITS-1){1'b1}}};
      end
      return r;
   endfunction

endpackage

`default_nettype wire

@@ sv/flas_ctrl.sv @@
// ----------------------------------------------------------------------------
// flas_ctrl
// Sequencer for the slicer: walks each sample through the datapath steps
// and owns the handshakes and the result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module flas_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output flas_pkg::cmd_type     cmd
);
   import flas_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      out_free;

   // Output register can take a beat when empty or being drained
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_DC_MUL;
         ST_DC_MUL: state_in = ST_DC_UPD;
         ST_DC_UPD: state_in = ST_CENTER;
         ST_CENTER: state_in = ST_DECIDE;
         ST_DECIDE: state_in = ST_LV_MUL;
         ST_LV_MUL: state_in = ST_LV_UPD;
         ST_LV_UPD: state_in = ST_TH_MUL;
         ST_TH_MUL: state_in = ST_TH_UPD;
         ST_TH_UPD: state_in = ST_DONE;
         ST_DONE:   if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Command outputs
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall  = 1'b0;
            cmd.load_x = req_valid;
         end
         ST_DC_MUL: cmd.dc_mul   = 1'b1;
         ST_DC_UPD: cmd.dc_upd   = 1'b1;
         ST_CENTER: cmd.center   = 1'b1;
         ST_DECIDE: cmd.decide   = 1'b1;
         ST_LV_MUL: cmd.lv_mul   = 1'b1;
         ST_LV_UPD: cmd.lv_upd   = 1'b1;
         ST_TH_MUL: cmd.th_mul   = 1'b1;
         ST_TH_UPD: cmd.th_upd   = 1'b1;
         ST_DONE:   cmd.load_rsp = out_free;
         default:   cmd          = '0;
      endcase
   end

   // Result valid flag
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

@@ sv/flas_dpath.sv @@
// ----------------------------------------------------------------------------
// flas_dpath
// Datapath for the slicer: gain registers, tracked levels, one shared gain
// multiplier, the divide-by-three multiplier and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module flas_dpath (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   input  wire flas_pkg::cmd_type                         cmd,
   input  wire logic signed [flas_pkg::SAMPLE_BITS-1:0]   req_sample_in,
   input  wire logic                                      csr_write_en,
   input  wire logic [flas_pkg::CSR_IDX_BITS-1:0]         csr_index,
   input  wire logic [flas_pkg::GAIN_BITS-1:0]            csr_wdata,
   output logic [1:0]                                     rsp_symbol
);
   import flas_pkg::*;

   // Configuration
   logic [GAIN_BITS-1:0] avg_gain_ff;
   logic [GAIN_BITS-1:0] decay_gain_ff;

   // Tracked state
   logic signed [STATE_BITS-1:0] dc_ff;
   logic signed [STATE_BITS-1:0] peak_ff;
   logic signed [STATE_BITS-1:0] trough_ff;
   logic signed [STATE_BITS-1:0] high_thr_ff;
   logic signed [STATE_BITS-1:0] low_thr_ff;

   // Per-item working registers
   logic signed [STATE_BITS-1:0] x_ff;
   logic signed [STATE_BITS-1:0] x_in;
   logic signed [STATE_BITS-1:0] c_ff;
   logic signed [STATE_BITS-1:0] c_in;
   logic signed [PROD_BITS-1:0]  prod_ff;
   logic signed [PROD_BITS-1:0]  prod_in;
   logic                         side_pos_ff;
   logic                         side_pos_in;
   logic                         beyond_ff;
   logic                         beyond_in;
   logic [1:0]                   sym_ff;
   logic [STATE_BITS-1:0]        quot_ff;
   logic [STATE_BITS-1:0]        quot_in;
   logic                         neg_ff;
   logic                         neg_in;
   logic [1:0]                   rsp_symbol_ff;

   // Shared multiplier operands
   logic signed [STATE_BITS-1:0] mul_a;
   logic signed [STATE_BITS-1:0] mul_b;
   logic [GAIN_BITS-1:0]         mul_g;
   logic signed [DIFF_BITS-1:0]  diff;

   // Update path
   logic signed [PROD_BITS-1:0]  rounded;
   logic signed [STEP_BITS-1:0]  step;
   logic signed [STATE_BITS-1:0] level;
   logic signed [STATE_BITS-1:0] upd_base;
   logic signed [STATE_BITS-1:0] upd_val;

   // Threshold path
   logic signed [MAG_BITS-1:0]   twice;
   logic [MAG_BITS-1:0]          mag;
   logic [DIV_PROD_BITS-1:0]     qprod;
   logic signed [STATE_BITS-1:0] thr_val;

   // Sample widened to the state format
   assign x_in = STATE_BITS'(req_sample_in) <<< FRAC_EXTRA;

   // Level on the side chosen for this item
   assign level = side_pos_ff ? peak_ff : trough_ff;

   // Operand select: DC average step, or level step / decay
   always_comb begin
      mul_a = dc_ff;
      mul_b = x_ff;
      mul_g = avg_gain_ff;
      if (cmd.lv_mul) begin
         mul_a = level;
         mul_b = beyond_ff ? c_ff : dc_ff;
         mul_g = beyond_ff ? avg_gain_ff : decay_gain_ff;
      end
   end

   assign diff    = DIFF_BITS'(mul_b) - DIFF_BITS'(mul_a);
   assign prod_in = PROD_BITS'(diff) * PROD_BITS'($signed({1'b0, mul_g}));

   // Round half up, floor shift, add to base and clamp
   assign rounded  = prod_ff + PROD_BITS'(64'd1 << (GAIN_BITS - 1));
   assign step     = STEP_BITS'(rounded >>> GAIN_BITS);
   assign upd_base = cmd.lv_upd ? level : dc_ff;
   assign upd_val  = sat_state(SUM_BITS'(upd_base) + SUM_BITS'(step));

   // Centered sample
   assign c_in = sat_state(SUM_BITS'(x_ff) - SUM_BITS'(dc_ff));

   // Decision: zero counts as the negative side, equality is not beyond
   always_comb begin
      side_pos_in = !c_ff[STATE_BITS-1] && (c_ff != '0);
      if (side_pos_in) begin
         beyond_in = c_ff > high_thr_ff;
      end else begin
         beyond_in = c_ff < low_thr_ff;
      end
   end

   // Two thirds of the level, truncated toward zero, on the magnitude
   assign twice   = {level, 1'b0};
   assign neg_in  = twice[MAG_BITS-1];
   assign mag     = neg_in ? MAG_BITS'(-twice) : MAG_BITS'(twice);
   assign qprod   = DIV_PROD_BITS'(mag) * DIV_PROD_BITS'(RECIP3);
   assign quot_in = qprod[DIV_SHIFT +: STATE_BITS];
   assign thr_val = neg_ff ? -$signed(quot_ff) : $signed(quot_ff);

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         avg_gain_ff   <= AVG_GAIN_RESET;
         decay_gain_ff <= DECAY_GAIN_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_AVG_GAIN:   avg_gain_ff   <= csr_wdata;
            CSR_DECAY_GAIN: decay_gain_ff <= csr_wdata;
            default:        avg_gain_ff   <= avg_gain_ff;
         endcase
      end
   end

   // Tracked levels and thresholds
   always_ff @(posedge clock) begin
      if (reset) begin
         dc_ff       <= '0;
         peak_ff     <= '0;
         trough_ff   <= '0;
         high_thr_ff <= '0;
         low_thr_ff  <= '0;
      end else begin
         if (cmd.dc_upd) begin
            dc_ff <= upd_val;
         end
         if (cmd.lv_upd && side_pos_ff) begin
            peak_ff <= upd_val;
         end
         if (cmd.lv_upd && !side_pos_ff) begin
            trough_ff <= upd_val;
         end
         if (cmd.th_upd && side_pos_ff) begin
            high_thr_ff <= thr_val;
         end
         if (cmd.th_upd && !side_pos_ff) begin
            low_thr_ff <= thr_val;
         end
      end
   end

   // Working registers, loaded by command only
   always_ff @(posedge clock) begin
      if (cmd.load_x) begin
         x_ff <= x_in;
      end
      if (cmd.dc_mul || cmd.lv_mul) begin
         prod_ff <= prod_in;
      end
      if (cmd.center) begin
         c_ff <= c_in;
      end
      if (cmd.decide) begin
         side_pos_ff <= side_pos_in;
         beyond_ff   <= beyond_in;
         sym_ff      <= {side_pos_in, side_pos_in ~^ beyond_in};
      end
      if (cmd.th_mul) begin
         quot_ff <= quot_in;
         neg_ff  <= neg_in;
      end
      if (cmd.load_rsp) begin
         rsp_symbol_ff <= sym_ff;
      end
   end

   assign rsp_symbol = rsp_symbol_ff;

endmodule

`default_nettype wire

@@ sv/four_level_adaptive_slicer.sv @@
// ----------------------------------------------------------------------------
// four_level_adaptive_slicer
// Four-level symbol slicer with adaptive DC, peak and trough tracking.
// ----------------------------------------------------------------------------
//
//   channel  ports                         direction  beat
//   req      req_valid/req_stall           in         one Q15 sample
//   rsp      rsp_valid/rsp_stall           out        one 2-bit symbol
//   csr      csr_write_en/index/wdata      in         one gain register write
//
// Each accepted sample runs through the DC, centering, decision, level and
// threshold steps before its result is loaded, and no new sample is accepted
// until then; the steps form a chain through the shared gain multiplier and
// the divide-by-three multiplier. Reset is synchronous and clears all levels
// and thresholds and loads the gain defaults. A stalled result sits in the
// output register while the next sample is accepted and worked on.
// ----------------------------------------------------------------------------
`default_nettype none

module four_level_adaptive_slicer (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   input  wire logic                                      req_valid,
   output logic                                           req_stall,
   input  wire logic signed [flas_pkg::SAMPLE_BITS-1:0]   req_sample_in,
   output logic                                           rsp_valid,
   input  wire logic                                      rsp_stall,
   output logic [1:0]                                     rsp_symbol,
   input  wire logic                                      csr_write_en,
   input  wire logic [flas_pkg::CSR_IDX_BITS-1:0]         csr_index,
   input  wire logic [flas_pkg::GAIN_BITS-1:0]            csr_wdata
);
   import flas_pkg::*;

   cmd_type cmd;

   // Sequencer
   flas_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // Arithmetic and state
   flas_dpath u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .req_sample_in (req_sample_in),
      .csr_write_en  (csr_write_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .rsp_symbol    (rsp_symbol)
   );

endmodule

`default_nettype wire

@@ sv/flas_checker.sv @@
// ----------------------------------------------------------------------------
// flas_checker
// Port-level checks for the slicer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module flas_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_stall,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [1:0] rsp_symbol
);

   // Idle with no result right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("slicer not idle after reset");

   // One sample in flight: an accepted beat blocks the next cycle
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("sample accepted while another is in flight");

   // A new result only comes out of a sample in flight
   a_rsp_from_item: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared with no sample in flight");

   // Stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_symbol))
      else $error("stalled result changed");

endmodule

bind four_level_adaptive_slicer flas_checker u_flas_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_valid),
   .req_stall  (req_stall),
   .rsp_valid  (rsp_valid),
   .rsp_stall  (rsp_stall),
   .rsp_symbol (rsp_symbol)
);

`default_nettype wire

@@ tb/tb_four_level_adaptive_slicer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_four_level_adaptive_slicer
// Self-checking bench for the four-level adaptive slicer: a queue-fed sample
// driver, a random stall on the symbol side, and a bit-true tracker of the
// DC average, peak, trough and thresholds that predicts every symbol.
// ----------------------------------------------------------------------------

module tb_four_level_adaptive_slicer;

   import flas_pkg::*;

   // Symbol codes
   localparam logic [1:0] SYM_BELOW_LOW  = 2'd0;
   localparam logic [1:0] SYM_LOW_ZERO   = 2'd1;
   localparam logic [1:0] SYM_ZERO_HIGH  = 2'd2;
   localparam logic [1:0] SYM_ABOVE_HIGH = 2'd3;

   localparam int RANDOM_PHASES   = 12;
   localparam int PHASE_SAMPLES   = 115;
   localparam int MAX_REPORTS     = 10;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                          req_valid     = 1'b0;
   logic                          req_stall;
   logic signed [SAMPLE_BITS-1:0] req_sample_in = '0;
   logic                          rsp_valid;
   logic                          rsp_stall     = 1'b0;
   logic [1:0]                    rsp_symbol;
   logic                          csr_write_en  = 1'b0;
   logic [CSR_IDX_BITS-1:0]       csr_index     = CSR_AVG_GAIN;
   logic [GAIN_BITS-1:0]          csr_wdata     = '0;

   four_level_adaptive_slicer uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_sample_in (req_sample_in),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_symbol    (rsp_symbol),
      .csr_write_en  (csr_write_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Bench state
   logic signed [SAMPLE_BITS-1:0] sample_queue[$];
   logic [1:0]                    symbol_fifo[$];
   logic                          req_taken = 1'b0;
   int                            req_gap = 0;
   int                            rsp_hold = 0;
   int                            req_idle_pct = 0;
   int                            rsp_idle_pct = 0;
   int                            fsk_span = 10000;
   int                            fsk_offset = 0;
   int                            errors = 0;
   int                            samples_sent = 0;
   int                            symbols_checked = 0;
   int                            gain_writes = 0;
   int                            sym_hist[4] = '{0, 0, 0, 0};

   // Tracker state, same widths as the block
   logic [GAIN_BITS-1:0]          trk_avg_gain   = AVG_GAIN_RESET;
   logic [GAIN_BITS-1:0]          trk_decay_gain = DECAY_GAIN_RESET;
   logic signed [STATE_BITS-1:0]  trk_dc    = '0;
   logic signed [STATE_BITS-1:0]  trk_peak  = '0;
   logic signed [STATE_BITS-1:0]  trk_trough = '0;
   logic signed [STATE_BITS-1:0]  trk_hi_th = '0;
   logic signed [STATE_BITS-1:0]  trk_lo_th = '0;

   // ------------------------------------------------------------------------
   // Symbol predictor
   // ------------------------------------------------------------------------
   function automatic longint clamp_state(longint v);
      longint hi;
      longint lo;
      hi = (longint'(1) << (STATE_BITS - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
   endfunction

   // a + g*(b - a); product rounded half up, arithmetic shift is a floor
   function automatic longint track_toward(longint a, longint b, longint g);
      longint prod;
      prod = (b - a) * g + (longint'(1) << (GAIN_BITS - 1));
      return clamp_state(a + (prod >>> GAIN_BITS));
   endfunction

   function automatic logic [1:0] slice_sample(logic signed [SAMPLE_BITS-1:0] s);
      longint     x;
      longint     dc;
      longint     c;
      longint     pk;
      longint     tr;
      logic [1:0] sym;
      x  = longint'(s) * (longint'(1) << FRAC_EXTRA);
      pk = trk_peak;
      tr = trk_trough;
      dc = track_toward(trk_dc, x, longint'(trk_avg_gain));
      c  = clamp_state(x - dc);
      // a centered value of zero goes to the negative side
      if (c > 0) begin
         if (c > longint'(trk_hi_th)) begin
            pk  = track_toward(pk, c, longint'(trk_avg_gain));
            sym = SYM_ABOVE_HIGH;
         end else begin
            pk  = track_toward(pk, dc, longint'(trk_decay_gain));
            sym = SYM_ZERO_HIGH;
         end
      end else begin
         if (c < longint'(trk_lo_th)) begin
            tr  = track_toward(tr, c, longint'(trk_avg_gain));
            sym = SYM_BELOW_LOW;
         end else begin
            tr  = track_toward(tr, dc, longint'(trk_decay_gain));
            sym = SYM_LOW_ZERO;
         end
      end
      trk_dc     = STATE_BITS'(dc);
      trk_peak   = STATE_BITS'(pk);
      trk_trough = STATE_BITS'(tr);
      // division truncates toward zero
      trk_hi_th  = STATE_BITS'((2 * pk) / 3);
      trk_lo_th  = STATE_BITS'((2 * tr) / 3);
      return sym;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   // A gap with probability pct percent: mostly short ones, a few long ones
   function automatic int pick_gap(int pct);
      if (int'($urandom_range(99)) >= pct) return 0;
      if ($urandom_range(9) == 0) return int'($urandom_range(40, 10));
      return int'($urandom_range(3, 1));
   endfunction

   // 4-level FSK-like samples with offset and noise, some raw noise, some extremes
   function automatic logic signed [SAMPLE_BITS-1:0] next_sample();
      int pick;
      int lvl;
      int noise;
      int v;
      pick  = int'($urandom_range(99));
      noise = fsk_span / 8 + 1;
      if (pick < 80) begin
         lvl = int'($urandom_range(3)) * 2 - 3;
         v = fsk_offset + lvl * fsk_span / 3 + int'($urandom_range(2 * noise)) - noise;
      end else if (pick < 92) begin
         v = int'($urandom_range(65535)) - 32768;
      end else begin
         case ($urandom_range(3))
            0: v = -32768;
            1: v = 32767;
            2: v = 0;
            default: v = int'($urandom_range(8)) - 4;
         endcase
      end
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[SAMPLE_BITS-1:0];
   endfunction

   function automatic logic [GAIN_BITS-1:0] pick_gain(int mode, int lo, int hi);
      case (mode)
         0: begin
            case ($urandom_range(3))
               0: return '0;
               1: return 16'd1;
               2: return 16'd32768;
               default: return 16'hFFFF;
            endcase
         end
         1: return GAIN_BITS'($urandom);
         default: return GAIN_BITS'($urandom_range(hi, lo));
      endcase
   endfunction

   // Block is idle once no sample is pending or presented and no symbol owed
   task automatic wait_idle();
      while (sample_queue.size() != 0 || req_valid || symbol_fifo.size() != 0)
         @(posedge clock);
   endtask

   // Writes both gain registers on consecutive cycles
   task automatic set_gains(logic [GAIN_BITS-1:0] avg, logic [GAIN_BITS-1:0] dec);
      wait_idle();
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= CSR_AVG_GAIN;
      csr_wdata    <= avg;
      @(negedge clock);
      csr_index    <= CSR_DECAY_GAIN;
      csr_wdata    <= dec;
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // Sample driver: new beat at the falling edge once the last one was taken
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      if (!reset && (!req_valid || req_taken)) begin
         if (req_gap != 0) begin
            req_gap   <= req_gap - 1;
            req_valid <= 1'b0;
         end else if (sample_queue.size() != 0) begin
            req_valid     <= 1'b1;
            req_sample_in <= sample_queue.pop_front();
            req_gap       <= pick_gap(req_idle_pct);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Symbol side back-pressure
   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_hold != 0) begin
            rsp_stall <= 1'b1;
            rsp_hold  <= rsp_hold - 1;
         end else begin
            rsp_stall <= 1'b0;
            rsp_hold  <= pick_gap(rsp_idle_pct);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: register writes, symbol check, prediction on each sample beat
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      logic [1:0] want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && !req_stall;
         if (csr_write_en) begin
            gain_writes++;
            if (csr_index == CSR_AVG_GAIN) trk_avg_gain = csr_wdata;
            else trk_decay_gain = csr_wdata;
         end
         if (rsp_valid && !rsp_stall) begin
            if (symbol_fifo.size() == 0) begin
               errors++;
               if (errors <= MAX_REPORTS)
                  $display("%0t: symbol %0d with none expected", $realtime, rsp_symbol);
            end else begin
               want = symbol_fifo.pop_front();
               symbols_checked++;
               sym_hist[rsp_symbol]++;
               if (rsp_symbol !== want) begin
                  errors++;
                  if (errors <= MAX_REPORTS)
                     $display("%0t: symbol mismatch, expected %0d, got %0d",
                              $realtime, want, rsp_symbol);
               end
            end
         end
         if (req_valid && !req_stall) begin
            samples_sent++;
            symbol_fifo.push_back(slice_sample(req_sample_in));
         end
      end
   end

   // ------------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------------
   initial begin
      int mode;
      int k;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: centered zero, then a sample landing exactly on the high
      // threshold (alpha one half builds peak 192, threshold 128; alpha zero
      // freezes the average at 384 so a sample of 2 centers at 128)
      req_idle_pct = 30;
      rsp_idle_pct = 30;
      set_gains(16'd32768, DECAY_GAIN_RESET);
      sample_queue = '{16'sd0, 16'sd3};
      set_gains(16'd0, DECAY_GAIN_RESET);
      sample_queue = '{16'sd2, 16'sd32767, -16'sd32768, -16'sd1, 16'sd1};

      // Full gains drive the average to the top of its range
      set_gains(16'hFFFF, 16'hFFFF);
      sample_queue = '{-16'sd32768, 16'sd0, 16'sd32767, 16'sd32767};

      // Frozen high average: most negative sample saturates the centered value
      set_gains(16'd0, 16'd0);
      sample_queue = '{-16'sd32768, -16'sd1, 16'sd32767};

      // Reset gains, extremes and mid values
      set_gains(AVG_GAIN_RESET, DECAY_GAIN_RESET);
      sample_queue = '{-16'sd32768, 16'sd32767, 16'sd100, -16'sd100, 16'sd0,
                       16'sd12345, -16'sd12345};

      // Random phases, each with its own gains, signal shape and idling
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         mode = (ph < 2) ? 2 : int'($urandom_range(9));
         mode = (mode < 2) ? 0 : (mode < 4) ? 1 : 2;
         set_gains(pick_gain(mode, 50, 5000), pick_gain(mode, 0, 300));
         fsk_span     = int'($urandom_range(30000, 1500));
         fsk_offset   = int'($urandom_range(8000)) - 4000;
         req_idle_pct = (ph % 4 == 1) ? 0 : int'($urandom_range(60));
         rsp_idle_pct = (ph % 4 == 2) ? 0 : int'($urandom_range(60));
         k = PHASE_SAMPLES + int'($urandom_range(10));
         repeat (k) sample_queue.push_back(next_sample());
      end

      wait_idle();
      repeat (30) @(posedge clock);
      $display("Sent %0d samples over %0d gain writes; checked %0d symbols",
               samples_sent, gain_writes, symbols_checked);
      $display("Symbol counts 0/1/2/3: %0d %0d %0d %0d, mismatches %0d",
               sym_hist[0], sym_hist[1], sym_hist[2], sym_hist[3], errors);
      if (errors == 0 && symbol_fifo.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #5_000_000;
      $display("Timeout with %0d symbols outstanding", symbol_fifo.size());
      $display("Regression FAIL");
      $finish;
   end

endmodule
